// File: src/ssf_pkg.sv
// Shared types, constants and segment lookup for the speed display frame encoder.
package ssf_pkg;

	localparam int unsigned DIGITS = 4;
	localparam logic [7:0] CMD_BASE = 8'h7A;
	localparam logic [14:0] SHOW_LIMIT = 15'd10000;
	localparam logic [2:0] FRAME_LAST = 3'd7;

	localparam logic [7:0] OVER_PATTERN [DIGITS] = '{8'd57, 8'd9, 8'd9, 8'd15};

	typedef struct packed {
		logic       over;
		logic [3:0] thou;
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] unit;
	} digit_set_t;

	// Segment a is bit 0, segment g is bit 6.
	function automatic logic [7:0] seg_code(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'd63;
			4'd1: s = 8'd6;
			4'd2: s = 8'd91;
			4'd3: s = 8'd79;
			4'd4: s = 8'd102;
			4'd5: s = 8'd109;
			4'd6: s = 8'd125;
			4'd7: s = 8'd7;
			4'd8: s = 8'd127;
			4'd9: s = 8'd111;
			default: s = 8'd0;
		endcase
		return s;
	endfunction

endpackage

// File: src/ssf_digits.sv
// Pipelined binary to four decimal digit conversion with overflow flag.
module ssf_digits
	import ssf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [14:0] speed,
	output logic        dig_valid,
	input  logic        dig_ready,
	output digit_set_t  digits
);

	logic        vld_s1, vld_s2, vld_s3, vld_q;
	logic [14:0] v_s1;
	logic        over_s2, over_s3;
	logic [3:0]  thou_s2, thou_s3, hund_s3;
	logic [9:0]  rem_s2;
	logic [6:0]  rem_s3;
	digit_set_t  digits_q;
	logic        rdy_s2, rdy_s3, rdy_q;

	logic [29:0] prod1;
	logic [5:0]  thou_w;
	logic [15:0] thou_x1000;
	logic [15:0] rem1_w;
	logic [19:0] prod2;
	logic [3:0]  hund_w;
	logic [9:0]  rem2_w;
	logic [14:0] prod3;
	logic [3:0]  tens_w;
	logic [6:0]  unit_w;

	assign rdy_q    = !vld_q || dig_ready;
	assign rdy_s3   = !vld_s3 || rdy_q;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign in_ready = !vld_s1 || rdy_s2;

	// Division by constants as reciprocal multiplies; each is exact for speeds below SHOW_LIMIT.
	always_comb begin
		prod1      = 30'(v_s1) * 30'd16778;
		thou_w     = prod1[29:24];
		thou_x1000 = 16'(thou_w) * 16'd1000;
		rem1_w     = 16'(v_s1) - thou_x1000;

		prod2  = 20'(rem_s2) * 20'd656;
		hund_w = prod2[19:16];
		rem2_w = rem_s2 - 10'(10'(hund_w) * 10'd100);

		prod3  = 15'(rem_s3) * 15'd205;
		tens_w = prod3[14:11];
		unit_w = rem_s3 - 7'(7'(tens_w) * 7'd10);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (in_ready) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_q) vld_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) v_s1 <= speed;
		if (rdy_s2 && vld_s1) begin
			over_s2 <= (v_s1 >= SHOW_LIMIT);
			thou_s2 <= thou_w[3:0];
			rem_s2  <= rem1_w[9:0];
		end
		if (rdy_s3 && vld_s2) begin
			over_s3 <= over_s2;
			thou_s3 <= thou_s2;
			hund_s3 <= hund_w;
			rem_s3  <= rem2_w[6:0];
		end
		if (rdy_q && vld_s3) begin
			digits_q.over <= over_s3;
			digits_q.thou <= thou_s3;
			digits_q.hund <= hund_s3;
			digits_q.tens <= tens_w;
			digits_q.unit <= unit_w[3:0];
		end
	end

	assign dig_valid = vld_q;
	assign digits    = digits_q;

	a_digits_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && !digits_q.over |-> digits_q.thou <= 4'd9 && digits_q.hund <= 4'd9 &&
			digits_q.tens <= 4'd9 && digits_q.unit <= 4'd9)
		else $error("decimal digit out of range");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !rdy_s2 |=> vld_s1 && $stable(v_s1))
		else $error("stage one lost its item while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && !dig_ready |=> vld_q && $stable(digits_q))
		else $error("digit register changed while stalled");

endmodule

// File: src/speed_to_seven_segment_frames_unit.sv
// Top level: speed value to an eight-byte seven-segment display frame.
// A frame's first byte is offered once its item has passed stages s1, s2, s3, the digit
// register and the frame register. The single byte-wide output channel bounds the rate;
// a four-register digit pipeline in front of the frame register takes new items meanwhile.
// Reset (arst_n, asynchronous, active low) empties the pipeline and the frame register.
module speed_to_seven_segment_frames_unit
	import ssf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [14:0] speed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last
);

	logic       dig_valid, dig_ready;
	digit_set_t digits;

	logic             fvld_q;
	logic [2:0]       cnt_q;
	logic [3:0][7:0]  seg_q;
	logic [3:0][3:0]  dig_vec;
	logic             frame_done;

	ssf_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.speed     (speed),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.digits    (digits)
	);

	assign frame_done = fvld_q && out_ready && (cnt_q == FRAME_LAST);
	assign dig_ready  = !fvld_q || frame_done;
	assign dig_vec    = {digits.unit, digits.tens, digits.hund, digits.thou};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvld_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			if (dig_ready) fvld_q <= dig_valid;
			if (fvld_q && out_ready) cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (dig_ready && dig_valid) begin
			for (int k = 0; k < DIGITS; k++) begin
				seg_q[k] <= digits.over ? OVER_PATTERN[k] : seg_code(dig_vec[k]);
			end
		end
	end

	// Even positions carry the digit-select command, odd ones the segment pattern.
	assign out_valid = fvld_q;
	assign out_byte  = cnt_q[0] ? seg_q[cnt_q[2:1]] : 8'(CMD_BASE + 8'(cnt_q[2:1]) + 8'd1);
	assign last      = (cnt_q == FRAME_LAST);

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!fvld_q |-> cnt_q == 3'd0)
		else $error("byte counter not at frame start while empty");

	a_frame_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && cnt_q == $past(cnt_q) + 3'd1)
		else $error("frame broke off before its last byte");

	a_cmd_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cnt_q[0] |-> out_byte[7:3] == 5'b01111 && !last)
		else $error("command byte out of range");

endmodule

// File: dv/speed_to_seven_segment_frames_unit_test.sv
// Testbench for the speed to seven-segment frame encoder: queued stimulus, frame prediction and byte checks.
module speed_to_seven_segment_frames_unit_test;
	import ssf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_ITEMS = 270;
	localparam int unsigned MAX_GAP = 18;
	localparam int unsigned LONG_HOLD = 300;
	localparam int unsigned IDLE_LIMIT = 3000;
	localparam int unsigned TAIL_CYCLES = 20;

	localparam logic [7:0] SEG_OF_DIGIT [10] = '{
		8'd63, 8'd6, 8'd91, 8'd79, 8'd102, 8'd109, 8'd125, 8'd7, 8'd127, 8'd111
	};

	typedef struct {
		logic [14:0] speed;
		int unsigned gap;
		bit          drain;
	} speed_item_t;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} frame_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [14:0] speed = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        last;

	speed_item_t speeds_pending [$];
	frame_byte_t frame_bytes_due [$];

	bit          in_taken = 1'b0;
	bit          out_taken = 1'b0;
	int unsigned mismatches = 0;

	speed_to_seven_segment_frames_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.speed     (speed),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		mismatches++;
		$display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Works out the eight bytes that one speed value turns into.
	task automatic queue_frame_for_speed(input logic [14:0] v);
		int unsigned n;
		logic [7:0] seg [DIGITS];
		frame_byte_t b;
		n = 32'(v);
		if (n < 10000) begin
			seg[0] = SEG_OF_DIGIT[(n / 1000) % 10];
			seg[1] = SEG_OF_DIGIT[(n / 100) % 10];
			seg[2] = SEG_OF_DIGIT[(n / 10) % 10];
			seg[3] = SEG_OF_DIGIT[n % 10];
		end else begin
			for (int k = 0; k < DIGITS; k++)
				seg[k] = OVER_PATTERN[k];
		end
		for (int k = 0; k < DIGITS; k++) begin
			b.value = CMD_BASE + 8'(k + 1);
			b.last = 1'b0;
			frame_bytes_due.push_back(b);
			b.value = seg[k];
			b.last = (k == DIGITS - 1);
			frame_bytes_due.push_back(b);
		end
	endtask

	// Handshakes are sampled at the rising edge; the drivers act on them at the falling edge.
	always @(posedge clk) begin
		frame_byte_t want;
		in_taken <= in_valid && in_ready;
		out_taken <= out_valid && out_ready;
		if (arst_n && in_valid && in_ready)
			queue_frame_for_speed(speed);
		if (arst_n && out_valid && out_ready) begin
			if (frame_bytes_due.size() == 0) begin
				report_mismatch("byte with no frame pending", out_byte, 8'd0);
			end else begin
				want = frame_bytes_due.pop_front();
				if (out_byte !== want.value)
					report_mismatch("out_byte", out_byte, want.value);
				if (last !== want.last)
					report_mismatch("last", {7'd0, last}, {7'd0, want.last});
			end
		end
	end

	// Sender: each item waits out its gap, and a draining item also waits for the frames in flight.
	speed_item_t tx_item;
	bit          tx_armed = 1'b0;
	bit          tx_busy = 1'b0;
	int unsigned tx_wait = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken)
				tx_busy = 1'b0;
			if (!tx_busy && (tx_armed || speeds_pending.size() > 0)) begin
				if (!tx_armed) begin
					tx_item = speeds_pending.pop_front();
					tx_wait = tx_item.gap;
					tx_armed = 1'b1;
				end
				if (tx_item.drain && frame_bytes_due.size() != 0) begin
				end else if (tx_wait > 0) begin
					tx_wait--;
				end else begin
					speed <= tx_item.speed;
					tx_busy = 1'b1;
					tx_armed = 1'b0;
				end
			end
			in_valid <= tx_busy;
		end
	end

	// Receiver: a fresh wait after every byte, steady stretches, and two long hold-offs.
	int unsigned rx_wait = 0;
	int unsigned rx_count = 0;
	bit          rx_steady = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				rx_count++;
				if (rx_count % 64 == 0)
					rx_steady = ($urandom_range(0, 2) == 0);
				if (rx_count == 150 || rx_count == 1500)
					rx_wait = LONG_HOLD;
				else if (rx_steady)
					rx_wait = 0;
				else
					rx_wait = $urandom_range(0, MAX_GAP);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			out_ready <= (rx_wait == 0);
		end
	end

	int unsigned idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[speed_to_seven_segment_frames_unit] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [14:0] directed [] = '{
			15'd0, 15'd1111, 15'd2222, 15'd3333, 15'd4444, 15'd5555, 15'd6666,
			15'd7777, 15'd8888, 15'd9999, 15'd10000, 15'd10001, 15'd32767,
			15'd16383, 15'd16384, 15'd1234, 15'd5678, 15'd9090, 15'd1000,
			15'd999, 15'd90, 15'd7
		};
		speed_item_t item;
		bit fast;
		int unsigned pick;

		foreach (directed[i]) begin
			item.speed = directed[i];
			item.gap = (i < 8) ? 0 : $urandom_range(0, MAX_GAP);
			item.drain = 1'b0;
			speeds_pending.push_back(item);
		end

		fast = 1'b0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0)
				fast = ($urandom_range(0, 2) == 0);
			pick = $urandom_range(0, 19);
			if (pick < 15)
				item.speed = 15'($urandom_range(0, 9999));
			else if (pick < 18)
				item.speed = 15'($urandom_range(10000, 32767));
			else
				item.speed = 15'($urandom);
			item.gap = fast ? 0 : $urandom_range(0, MAX_GAP);
			// The first random item and one midway wait until every frame has gone out.
			item.drain = (i == 0 || i == RANDOM_ITEMS / 2);
			speeds_pending.push_back(item);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (speeds_pending.size() == 0 && !tx_armed && !tx_busy);
		wait (frame_bytes_due.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("[speed_to_seven_segment_frames_unit] OK");
		else
			$display("[speed_to_seven_segment_frames_unit] ERROR");
		$finish;
	end

endmodule
